[hdl/rss_pkg.sv]
// Shared types and constants for the Rosenbrock step size search core.
// Holds the step table, the per-beat item record and register indexes.
// No dependencies.
package rss_pkg;

   localparam int MAX_STEPS   = 8;
   localparam int IDX_W       = 3;
   localparam int STEP_W      = 29;
   localparam int VALUE_W     = 48;
   localparam int WORD_W      = 32;
   localparam int COEF_B_W    = 31;
   localparam int COUNT_W     = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CELL_STAGES = 11;

   // Q0.32 steps, 0.1 / 10^i
   localparam logic [STEP_W-1:0] STEP_TABLE [MAX_STEPS] = '{
      29'd429496730, 29'd42949673, 29'd4294967, 29'd429497,
      29'd42950, 29'd4295, 29'd429, 29'd43
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_COUNT = 2'd0,
      CSR_COEF_A     = 2'd1,
      CSR_COEF_B     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     valid;
      logic signed [WORD_W-1:0] point_x;
      logic signed [WORD_W-1:0] point_y;
      logic signed [WORD_W-1:0] grad_x;
      logic signed [WORD_W-1:0] grad_y;
      logic [IDX_W-1:0]         best_index;
      logic [VALUE_W-1:0]       best_value;
   } item_type;

endpackage

[hdl/rss_if.sv]
// Channel interfaces for the Rosenbrock step size search core.
// Request, response and register write channels; uses rss_pkg.
interface rss_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [rss_pkg::WORD_W-1:0] point_x;
   logic signed [rss_pkg::WORD_W-1:0] point_y;
   logic signed [rss_pkg::WORD_W-1:0] grad_x;
   logic signed [rss_pkg::WORD_W-1:0] grad_y;
   modport source (output valid, point_x, point_y, grad_x, grad_y, input ready);
   modport sink (input valid, point_x, point_y, grad_x, grad_y, output ready);
endinterface

interface rss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rss_pkg::IDX_W-1:0]     best_index;
   logic [rss_pkg::STEP_W-1:0]    best_step;
   logic [rss_pkg::VALUE_W-1:0]   best_value;
   modport source (output valid, best_index, best_step, best_value, input ready);
   modport sink (input valid, best_index, best_step, best_value, output ready);
endinterface

interface rss_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rss_pkg::CSR_IDX_W-1:0] index;
   logic [rss_pkg::WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hdl/rss_cell.sv]
// One candidate-step cell: evaluates f at x - s*g and updates the running best.
// Eleven register stages, all advancing on en. Uses rss_pkg.
module rss_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic [rss_pkg::IDX_W-1:0]           cell_idx,
   input  logic                                active,
   input  logic signed [rss_pkg::WORD_W-1:0]   coef_a,
   input  logic [rss_pkg::COEF_B_W-1:0]        coef_b,
   input  rss_pkg::item_type                   item_in,
   output rss_pkg::item_type                   item_out
);

   rss_pkg::item_type itm_ff [rss_pkg::CELL_STAGES-1];
   rss_pkg::item_type out_ff, out_in;

   logic [rss_pkg::STEP_W-1:0] step_val;

   logic signed [61:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [61:0] r0, r1;
   logic signed [29:0] ss0, ss1;
   logic signed [32:0] y0_ff, y0_in, y1_ff, y1_in;
   logic signed [33:0] da, nda;
   logic signed [32:0] ny0;
   logic [32:0]        d_ff, d_in;
   logic [31:0]        ay0_ff, ay0_in;
   logic signed [32:0] y1_s3_ff, y1_s4_ff, y1_s5_ff;
   logic [65:0]        dd_ff, dd_in, sdd;
   logic [63:0]        aa_ff, aa_in, saa;
   logic [41:0]        term1_s5_ff, term1_in;
   logic [41:0]        term1_s6_ff, term1_s7_ff, term1_s8_ff, term1_s9_ff, term1_s10_ff;
   logic [39:0]        y0sq_ff, y0sq_in;
   logic signed [41:0] td, ntd;
   logic [40:0]        t_ff, t_in;
   logic [19:0]        th;
   logic [20:0]        tl;
   logic [39:0]        hh_ff, hh_in;
   logic [40:0]        hl_ff, hl_in;
   logic [41:0]        ll_ff, ll_in;
   logic [81:0]        sq;
   logic [57:0]        q_ff, q_in;
   logic [59:0]        bh_ff, bh_in, bl_ff, bl_in;
   logic [88:0]        bq;
   logic [64:0]        bv;
   logic [47:0]        term2_ff, term2_in;
   logic [48:0]        fs;
   logic [47:0]        fval;
   logic               take;

   always_comb begin
      // stage 1: step products
      step_val = rss_pkg::STEP_TABLE[cell_idx];
      p0_in    = $signed({1'b0, step_val}) * item_in.grad_x;
      p1_in    = $signed({1'b0, step_val}) * item_in.grad_y;

      // stage 2: round half up, new point
      r0    = p0_ff + 62'sh0_8000_0000;
      r1    = p1_ff + 62'sh0_8000_0000;
      ss0   = $signed(r0[61:32]);
      ss1   = $signed(r1[61:32]);
      y0_in = $signed({itm_ff[0].point_x[31], itm_ff[0].point_x})
              - $signed({{3{ss0[29]}}, ss0});
      y1_in = $signed({itm_ff[0].point_y[31], itm_ff[0].point_y})
              - $signed({{3{ss1[29]}}, ss1});

      // stage 3: magnitudes
      da     = $signed({{2{coef_a[31]}}, coef_a}) - $signed({y0_ff[32], y0_ff});
      nda    = -da;
      d_in   = da[33] ? nda[32:0] : da[32:0];
      ny0    = -y0_ff;
      ay0_in = y0_ff[32] ? ny0[31:0] : y0_ff[31:0];

      // stage 4: squares
      dd_in = d_ff * d_ff;
      aa_in = 64'(ay0_ff) * 64'(ay0_ff);

      // stage 5: reduce to 24 fraction bits
      sdd      = dd_ff + 66'd8388608;
      term1_in = sdd[65:24];
      saa      = aa_ff + 64'd8388608;
      y0sq_in  = saa[63:24];

      // stage 6
      td   = $signed({{9{y1_s5_ff[32]}}, y1_s5_ff}) - $signed({2'b00, y0sq_ff});
      ntd  = -td;
      t_in = td[41] ? ntd[40:0] : td[40:0];

      // stage 7: t^2 as partial products
      th    = t_ff[40:21];
      tl    = t_ff[20:0];
      hh_in = 40'(th) * 40'(th);
      hl_in = 41'(th) * 41'(tl);
      ll_in = 42'(tl) * 42'(tl);

      // stage 8
      sq   = {hh_ff, 42'd0} + {19'd0, hl_ff, 22'd0} + {40'd0, ll_ff} + 82'd8388608;
      q_in = sq[81:24];

      // stage 9: b*q in two halves
      bh_in = 60'(coef_b) * 60'(q_ff[57:29]);
      bl_in = 60'(coef_b) * 60'(q_ff[28:0]);

      // stage 10: reduce and saturate
      bq       = {bh_ff, 29'd0} + {29'd0, bl_ff} + 89'd8388608;
      bv       = bq[88:24];
      term2_in = (|bv[64:48]) ? '1 : bv[47:0];

      // stage 11: total and running best
      fs     = {7'd0, term1_s10_ff} + {1'b0, term2_ff};
      fval   = fs[48] ? '1 : fs[47:0];
      take   = active && ((cell_idx == '0) ||
                          (fval < itm_ff[rss_pkg::CELL_STAGES-2].best_value));
      out_in = itm_ff[rss_pkg::CELL_STAGES-2];
      if (take) begin
         out_in.best_index = cell_idx;
         out_in.best_value = fval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rss_pkg::CELL_STAGES-1; k++) begin
            itm_ff[k].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (en) begin
         itm_ff[0] <= item_in;
         for (int k = 1; k < rss_pkg::CELL_STAGES-1; k++) begin
            itm_ff[k] <= itm_ff[k-1];
         end
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         y0_ff        <= y0_in;
         y1_ff        <= y1_in;
         d_ff         <= d_in;
         ay0_ff       <= ay0_in;
         y1_s3_ff     <= y1_ff;
         dd_ff        <= dd_in;
         aa_ff        <= aa_in;
         y1_s4_ff     <= y1_s3_ff;
         term1_s5_ff  <= term1_in;
         y0sq_ff      <= y0sq_in;
         y1_s5_ff     <= y1_s4_ff;
         t_ff         <= t_in;
         term1_s6_ff  <= term1_s5_ff;
         hh_ff        <= hh_in;
         hl_ff        <= hl_in;
         ll_ff        <= ll_in;
         term1_s7_ff  <= term1_s6_ff;
         q_ff         <= q_in;
         term1_s8_ff  <= term1_s7_ff;
         bh_ff        <= bh_in;
         bl_ff        <= bl_in;
         term1_s9_ff  <= term1_s8_ff;
         term2_ff     <= term2_in;
         term1_s10_ff <= term1_s9_ff;
      end
   end

   assign item_out = out_ff;

endmodule

[hdl/rosenbrock_step_size_search_core.sv]
// Top level of the Rosenbrock step size search core.
// Holds the register file and a chain of rss_cell; uses rss_pkg and rss_if.
//
// Usage:
//   req_ch carries one point and gradient per beat (signed Q8.24).
//   rsp_ch returns one beat per request: best step index, the Q0.32 step
//   and the Q24.24 function value, in request order.
//   csr_ch writes step_count, coef_a and coef_b; always ready. Write only
//   while no request is in flight.
// Throughput: one request per cycle while rsp_ch is not stalling. The chain has
//   eight cells of eleven register stages each, one cell per candidate step.
// Reset: empties the pipeline and loads step_count 4, a 1.0, b 100.0.
// Stall: the last cell stage is the output register; while it holds an
//   untaken beat the whole chain freezes and req_ch.ready drops.
module rosenbrock_step_size_search_core (
   input  logic             clock,
   input  logic             reset,
   rss_req_if.sink          req_ch,
   rss_rsp_if.source        rsp_ch,
   rss_csr_if.sink          csr_ch
);

   logic [rss_pkg::COUNT_W-1:0]      step_count_ff, step_count_in;
   logic signed [rss_pkg::WORD_W-1:0] coef_a_ff, coef_a_in;
   logic [rss_pkg::COEF_B_W-1:0]     coef_b_ff, coef_b_in;
   logic [rss_pkg::COUNT_W-1:0]      steps_eff;
   logic                             en;

   rss_pkg::item_type link [rss_pkg::MAX_STEPS+1];

   assign csr_ch.ready = 1'b1;

   always_comb begin
      step_count_in = step_count_ff;
      coef_a_in     = coef_a_ff;
      coef_b_in     = coef_b_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (rss_pkg::csr_index_type'(csr_ch.index))
            rss_pkg::CSR_STEP_COUNT: step_count_in = csr_ch.data[rss_pkg::COUNT_W-1:0];
            rss_pkg::CSR_COEF_A:     coef_a_in     = $signed(csr_ch.data);
            rss_pkg::CSR_COEF_B:     coef_b_in     = csr_ch.data[rss_pkg::COEF_B_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= rss_pkg::COUNT_W'(4);
         coef_a_ff     <= 32'sd16777216;
         coef_b_ff     <= 31'd1677721600;
      end else begin
         step_count_ff <= step_count_in;
         coef_a_ff     <= coef_a_in;
         coef_b_ff     <= coef_b_in;
      end
   end

   always_comb begin
      if (step_count_ff == '0) begin
         steps_eff = rss_pkg::COUNT_W'(1);
      end else if (step_count_ff > rss_pkg::COUNT_W'(rss_pkg::MAX_STEPS)) begin
         steps_eff = rss_pkg::COUNT_W'(rss_pkg::MAX_STEPS);
      end else begin
         steps_eff = step_count_ff;
      end
   end

   assign en           = !link[rss_pkg::MAX_STEPS].valid || rsp_ch.ready;
   assign req_ch.ready = en;

   always_comb begin
      link[0]            = '0;
      link[0].valid      = req_ch.valid;
      link[0].point_x    = req_ch.point_x;
      link[0].point_y    = req_ch.point_y;
      link[0].grad_x     = req_ch.grad_x;
      link[0].grad_y     = req_ch.grad_y;
   end

   for (genvar g = 0; g < rss_pkg::MAX_STEPS; g++) begin : g_cell
      rss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_idx (rss_pkg::IDX_W'(g)),
         .active   (rss_pkg::COUNT_W'(g) < steps_eff),
         .coef_a   (coef_a_ff),
         .coef_b   (coef_b_ff),
         .item_in  (link[g]),
         .item_out (link[g+1])
      );
   end

   assign rsp_ch.valid      = link[rss_pkg::MAX_STEPS].valid;
   assign rsp_ch.best_index = link[rss_pkg::MAX_STEPS].best_index;
   assign rsp_ch.best_step  = rss_pkg::STEP_TABLE[link[rss_pkg::MAX_STEPS].best_index];
   assign rsp_ch.best_value = link[rss_pkg::MAX_STEPS].best_value;

endmodule

[tb/tb_rosenbrock_step_size_search_core.sv]
// Testbench for rosenbrock_step_size_search_core: directed and random beats, checked
// in order against a fixed-point line search predictor kept in a scoreboard class.
// Depends on rss_pkg, the rss_if interfaces and the core RTL.
module tb_rosenbrock_step_size_search_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rss_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [rss_pkg::VALUE_W-1:0]   VALUE_SAT    = '1;
   localparam logic [rss_pkg::WORD_W-1:0]    WORD_MAX     = 32'h7fff_ffff;
   localparam logic [rss_pkg::WORD_W-1:0]    WORD_MIN     = 32'h8000_0000;
   localparam int IDLE_PCT       = 21;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 113;
   localparam int HOLD_PHASE     = 2;
   localparam int STEADY_PHASE   = 5;

   typedef struct {
      logic [rss_pkg::IDX_W-1:0]   best_index;
      logic [rss_pkg::STEP_W-1:0]  best_step;
      logic [rss_pkg::VALUE_W-1:0] best_value;
   } search_result_type;

   class line_search_tracker;
      logic [rss_pkg::COUNT_W-1:0]       step_count;
      logic signed [rss_pkg::WORD_W-1:0] coef_a;
      logic [rss_pkg::COEF_B_W-1:0]      coef_b;
      search_result_type                 pending_searches[$];
      int                                errors;
      int                                checked;

      function new();
         step_count = 4'd4;
         coef_a     = 32'sd16777216;
         coef_b     = 31'd1677721600;
         errors     = 0;
         checked    = 0;
      endfunction

      task report(string msg);
         if (errors < 100) $display("%0t ns: %s", $time, msg);
         errors++;
      endtask

      function void write_register(logic [rss_pkg::CSR_IDX_W-1:0] index,
                                   logic [rss_pkg::WORD_W-1:0] data);
         case (index)
            rss_pkg::CSR_STEP_COUNT: step_count = data[rss_pkg::COUNT_W-1:0];
            rss_pkg::CSR_COEF_A:     coef_a = data;
            rss_pkg::CSR_COEF_B:     coef_b = data[rss_pkg::COEF_B_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] magnitude(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      function logic [127:0] round_q24(logic [127:0] p);
         return (p + 128'h80_0000) >> 24;
      endfunction

      function logic [rss_pkg::VALUE_W:0] clip_value(logic [127:0] v);
         return (v > 128'(VALUE_SAT)) ? {1'b0, VALUE_SAT} : v[rss_pkg::VALUE_W:0];
      endfunction

      // round half up of s*g / 2^32
      function longint step_offset(logic [rss_pkg::STEP_W-1:0] s, longint g);
         longint p;
         p = longint'({35'd0, s}) * g + 64'sd2147483648;
         return p >>> 32;
      endfunction

      function logic [rss_pkg::VALUE_W-1:0] rosen_value(longint y0, longint y1);
         longint                    a_val, t_val;
         logic [63:0]               d, ay0, t;
         logic [127:0]              term1, y0sq, q, term2;
         logic [rss_pkg::VALUE_W:0] sum;
         a_val = coef_a;
         d     = magnitude(a_val - y0);
         term1 = round_q24({64'd0, d} * {64'd0, d});
         ay0   = magnitude(y0);
         y0sq  = round_q24({64'd0, ay0} * {64'd0, ay0});
         t_val = y1 - longint'(y0sq[63:0]);
         t     = magnitude(t_val);
         q     = round_q24({64'd0, t} * {64'd0, t});
         term2 = round_q24({97'd0, coef_b} * q);
         sum   = clip_value(term1) + clip_value(term2);
         return (sum > {1'b0, VALUE_SAT}) ? VALUE_SAT : sum[rss_pkg::VALUE_W-1:0];
      endfunction

      function search_result_type predict_line_search(
            logic signed [rss_pkg::WORD_W-1:0] px, py, gx, gy);
         longint                      x0, x1, g0, g1;
         int                          n;
         logic [rss_pkg::VALUE_W-1:0] f;
         search_result_type           best;
         x0 = px;
         x1 = py;
         g0 = gx;
         g1 = gy;
         n = (step_count == 0) ? 1 :
             (step_count > rss_pkg::MAX_STEPS) ? rss_pkg::MAX_STEPS : step_count;
         best = '{default: '0};
         for (int i = 0; i < n; i++) begin
            f = rosen_value(x0 - step_offset(rss_pkg::STEP_TABLE[i], g0),
                            x1 - step_offset(rss_pkg::STEP_TABLE[i], g1));
            // strict compare: first minimum wins, saturated values tie
            if (i == 0 || f < best.best_value) begin
               best.best_index = rss_pkg::IDX_W'(i);
               best.best_step  = rss_pkg::STEP_TABLE[i];
               best.best_value = f;
            end
         end
         return best;
      endfunction

      function void note_request(logic signed [rss_pkg::WORD_W-1:0] px, py, gx, gy);
         pending_searches.push_back(predict_line_search(px, py, gx, gy));
      endfunction

      task check_result(logic [rss_pkg::IDX_W-1:0] idx, logic [rss_pkg::STEP_W-1:0] step,
                        logic [rss_pkg::VALUE_W-1:0] value);
         search_result_type want;
         checked++;
         if (pending_searches.size() == 0) begin
            report($sformatf("unexpected rsp beat: index %0d value %h", idx, value));
            return;
         end
         want = pending_searches.pop_front();
         if (idx !== want.best_index)
            report($sformatf("best_index %0d, want %0d", idx, want.best_index));
         if (step !== want.best_step)
            report($sformatf("best_step %0d, want %0d", step, want.best_step));
         if (value !== want.best_value)
            report($sformatf("best_value %h, want %h", value, want.best_value));
      endtask

      task close_out();
         if (pending_searches.size() != 0)
            report($sformatf("%0d rsp beats never arrived", pending_searches.size()));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   req_idle_en  = 1'b1;
   bit   rsp_idle_en  = 1'b1;
   bit   hold_off_req = 1'b0;
   int   items_sent   = 0;

   line_search_tracker tracker = new();

   rss_req_if req_ch();
   rss_rsp_if rsp_ch();
   rss_csr_if csr_ch();

   rosenbrock_step_size_search_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            tracker.write_register(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            tracker.note_request(req_ch.point_x, req_ch.point_y, req_ch.grad_x, req_ch.grad_y);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_result(rsp_ch.best_index, rsp_ch.best_step, rsp_ch.best_value);
      end
   end

   // rsp ready: random stalls, or one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_ch.ready <= !(rsp_idle_en && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[rosenbrock_step_size_search_core] ERROR");
      $finish;
   end

   function automatic logic [rss_pkg::WORD_W-1:0] q824(real r);
      if (r > 127.99) r = 127.99;
      else if (r < -127.99) r = -127.99;
      return $rtoi(r * 16777216.0);
   endfunction

   function automatic logic [rss_pkg::WORD_W-1:0] corner_word();
      case ($urandom_range(5))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         4: return q824(1.0);
         default: return 32'd1;
      endcase
   endfunction

   // valid stays high from one beat to the next unless a random idle gap is drawn
   task automatic push_item(logic [rss_pkg::WORD_W-1:0] px, py, gx, gy);
      while (req_idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      req_ch.grad_x  <= gx;
      req_ch.grad_y  <= gy;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic finish_batch();
      req_ch.valid <= 1'b0;
      while (tracker.checked < items_sent) @(posedge clock);
   endtask

   task automatic write_reg(logic [rss_pkg::CSR_IDX_W-1:0] index,
                            logic [rss_pkg::WORD_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_registers(logic [rss_pkg::WORD_W-1:0] count, a, b, bit stray);
      finish_batch();
      if (stray) write_reg(CSR_UNMAPPED, $urandom);
      write_reg(rss_pkg::CSR_STEP_COUNT, count);
      write_reg(rss_pkg::CSR_COEF_A, a);
      write_reg(rss_pkg::CSR_COEF_B, b);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic directed();
      // reset settings: 4 steps, a 1.0, b 100.0
      push_item(q824(1.0), q824(1.0), '0, '0);
      push_item('0, '0, '0, '0);
      push_item(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      push_item(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      push_item(WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
      push_item(WORD_MIN, WORD_MAX, 32'd1, '1);
      push_item(q824(0.5), q824(0.5), q824(-51.0), q824(50.0));
      push_item('0, '0, q824(-2.0), '0);
      push_item(q824(-1.0), q824(1.0), q824(-4.0), '0);
      // zero count behaves as one step
      set_registers(32'd0, q824(1.0), q824(100.0), 1'b0);
      push_item(q824(0.5), q824(0.5), q824(-51.0), q824(50.0));
      push_item(q824(-1.0), q824(1.0), q824(-4.0), '0);
      // count above the table clamps; stray write to the unmapped index
      set_registers(32'd15, q824(1.0), q824(100.0), 1'b1);
      push_item(q824(-1.0), q824(1.0), q824(-4.0), '0);
      push_item(q824(0.5), q824(0.5), q824(-51.0), q824(50.0));
      push_item(q824(-1.0), q824(1.0), q824(-0.004), q824(0.001));
      set_registers(32'd8, WORD_MAX, '0, 1'b0);
      push_item(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
      push_item(q824(100.0), '0, q824(-127.0), '0);
      push_item('0, '0, '0, '0);
      set_registers(32'd1, WORD_MIN, '1, 1'b0);
      push_item(WORD_MIN, '0, WORD_MIN, '0);
      push_item(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN);
      push_item(q824(-1.0), q824(1.0), q824(-4.0), '0);
   endtask

   task automatic random_item();
      real                        x0, x1;
      int                         kind;
      logic [rss_pkg::WORD_W-1:0] px, py, gx, gy;
      kind = $urandom_range(99);
      x0 = (real'($urandom_range(4000)) - 2000.0) / 1000.0;
      x1 = (real'($urandom_range(4000)) - 2000.0) / 1000.0;
      px = q824(x0);
      py = q824(x1);
      if (kind < 55) begin
         // descent direction from the nominal surface
         gx = q824(-2.0 * (1.0 - x0) - 400.0 * x0 * (x1 - x0 * x0));
         gy = q824(200.0 * (x1 - x0 * x0));
      end else if (kind < 80) begin
         gx = $signed($urandom) >>> $urandom_range(31);
         gy = $signed($urandom) >>> $urandom_range(31);
      end else if (kind < 92) begin
         px = $urandom;
         py = $urandom;
         gx = $urandom;
         gy = $urandom;
      end else begin
         px = corner_word();
         py = corner_word();
         gx = corner_word();
         gy = corner_word();
      end
      push_item(px, py, gx, gy);
   endtask

   task automatic random_phase(int p);
      logic [rss_pkg::WORD_W-1:0] count, a, b;
      count = $urandom_range(1, rss_pkg::MAX_STEPS);
      if (p == 3) count = 32'd0;
      if (p == 7) count = $urandom_range(rss_pkg::MAX_STEPS + 1, 15);
      if ($urandom_range(3) == 0) a = $urandom;
      else a = q824((real'($urandom_range(4000)) - 2000.0) / 1000.0);
      if ($urandom_range(3) == 0) b = $urandom;
      else b = q824(real'($urandom_range(120)));
      set_registers(count, a, b, $urandom_range(3) == 0);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      req_idle_en = (p != STEADY_PHASE);
      rsp_idle_en = (p != STEADY_PHASE);
      repeat (PHASE_ITEMS) random_item();
   endtask

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.point_x <= '0;
      req_ch.point_y <= '0;
      req_ch.grad_x  <= '0;
      req_ch.grad_y  <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= '0;
      csr_ch.data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      directed();
      for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);
      finish_batch();
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.close_out();
      if (tracker.errors == 0)
         $display("[rosenbrock_step_size_search_core] OK");
      else
         $display("[rosenbrock_step_size_search_core] ERROR");
      $finish;
   end

endmodule
